>>> hw/rtl/jzfs_pkg.sv
// ----------------------------------------------------------------------------
// jzfs_pkg
// Shared types and constants of the JPEG/ZIP filename scanner.
// ----------------------------------------------------------------------------
package jzfs_pkg;

	localparam logic [7:0]  SigByte0   = 8'h50;
	localparam logic [7:0]  SigByte1   = 8'h4B;
	localparam logic [7:0]  SigByte2   = 8'h03;
	localparam logic [7:0]  SigByte3   = 8'h04;
	localparam logic [7:0]  MarkPrefix = 8'hFF;
	localparam logic [7:0]  MarkSoi    = 8'hD8;
	localparam logic [7:0]  MarkEoi    = 8'hD9;
	localparam logic [4:0]  HdrSkip    = 5'd22;
	localparam logic [4:0]  ExtSkip    = 5'd2;
	localparam logic [15:0] CountMax   = 16'hFFFF;

	localparam logic KindName   = 1'b0;
	localparam logic KindStatus = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  name_byte;
		logic [15:0] file_index;
		logic        last_of_name;
		logic        jpg_start_seen;
		logic        jpg_end_seen;
		logic [15:0] files_found;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    name_vld;
		logic    status_vld;
		result_t name_res;
		result_t status_res;
	} step_t;

endpackage

>>> hw/rtl/jzfs_parser.sv
// ----------------------------------------------------------------------------
// jzfs_parser
// Byte window, marker flags and local-header parse state; one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module jzfs_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     data_byte,
	input  logic           end_of_stream,
	output jzfs_pkg::step_t step
);
	import jzfs_pkg::*;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SKIPHDR,
		PH_LENLO,
		PH_LENHI,
		PH_SKIPEXT,
		PH_NAME
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] window_q, window_d;
	logic [1:0]  fill_q, fill_d;
	logic [4:0]  hcount_q, hcount_d, hcount_inc;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] remain_q, remain_d, remain_dec;
	logic [15:0] count_q, count_d;
	logic        soi_q, soi_d, eoi_q, eoi_d;
	logic        name_vld;
	logic        marker_ok;

	assign marker_ok  = (fill_q != 2'd0) && (window_q[7:0] == MarkPrefix);
	assign hcount_inc = hcount_q + 5'd1;
	assign remain_dec = remain_q - 16'd1;

	always_comb begin
		phase_d  = phase_q;
		hcount_d = hcount_q;
		len_lo_d = len_lo_q;
		remain_d = remain_q;
		count_d  = count_q;
		soi_d    = soi_q | (marker_ok && (data_byte == MarkSoi));
		eoi_d    = eoi_q | (marker_ok && (data_byte == MarkEoi));
		name_vld = 1'b0;
		unique case (phase_q)
			PH_SEARCH: begin
				if (fill_q == 2'd3 && window_q == {SigByte0, SigByte1, SigByte2}
						&& data_byte == SigByte3) begin
					if (count_q != CountMax)
						count_d = count_q + 16'd1;
					hcount_d = '0;
					phase_d  = PH_SKIPHDR;
				end
			end
			PH_SKIPHDR: begin
				hcount_d = hcount_inc;
				if (hcount_inc >= HdrSkip) begin
					hcount_d = '0;
					phase_d  = PH_LENLO;
				end
			end
			PH_LENLO: begin
				len_lo_d = data_byte;
				phase_d  = PH_LENHI;
			end
			PH_LENHI: begin
				remain_d = {data_byte, len_lo_q};
				hcount_d = '0;
				phase_d  = PH_SKIPEXT;
			end
			PH_SKIPEXT: begin
				hcount_d = hcount_inc;
				if (hcount_inc >= ExtSkip) begin
					hcount_d = '0;
					phase_d  = (remain_q == 16'd0) ? PH_SEARCH : PH_NAME;
				end
			end
			PH_NAME: begin
				remain_d = remain_dec;
				name_vld = 1'b1;
				if (remain_dec == 16'd0)
					phase_d = PH_SEARCH;
			end
			default: phase_d = PH_SEARCH;
		endcase
		window_d = {window_q[15:0], data_byte};
		fill_d   = (fill_q == 2'd3) ? fill_q : fill_q + 2'd1;
	end

	always_comb begin
		step.name_vld                  = name_vld;
		step.status_vld                = end_of_stream;
		step.name_res                  = '0;
		step.name_res.kind             = KindName;
		step.name_res.name_byte        = data_byte;
		step.name_res.file_index       = (count_q == 16'd0) ? 16'd0 : count_q - 16'd1;
		step.name_res.last_of_name     = (remain_dec == 16'd0);
		step.name_res.last             = !end_of_stream;
		step.status_res                = '0;
		step.status_res.kind           = KindStatus;
		step.status_res.jpg_start_seen = soi_d;
		step.status_res.jpg_end_seen   = eoi_d;
		step.status_res.files_found    = count_d;
		step.status_res.last           = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			window_q <= '0;
			fill_q   <= '0;
			hcount_q <= '0;
			len_lo_q <= '0;
			remain_q <= '0;
			count_q  <= '0;
			soi_q    <= 1'b0;
			eoi_q    <= 1'b0;
		end else if (fire) begin
			if (end_of_stream) begin
				phase_q  <= PH_SEARCH;
				window_q <= '0;
				fill_q   <= '0;
				hcount_q <= '0;
				len_lo_q <= '0;
				remain_q <= '0;
				count_q  <= '0;
				soi_q    <= 1'b0;
				eoi_q    <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				window_q <= window_d;
				fill_q   <= fill_d;
				hcount_q <= hcount_d;
				len_lo_q <= len_lo_d;
				remain_q <= remain_d;
				count_q  <= count_d;
				soi_q    <= soi_d;
				eoi_q    <= eoi_d;
			end
		end
	end

endmodule

>>> hw/rtl/jzfs_outbuf.sv
// ----------------------------------------------------------------------------
// jzfs_outbuf
// Result register holding up to two results of one byte, sent in order.
// ----------------------------------------------------------------------------
module jzfs_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jzfs_pkg::step_t   step,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output jzfs_pkg::result_t res
);
	import jzfs_pkg::*;

	logic    name_vld_q, status_vld_q;
	result_t name_q, status_q;
	logic    pop;

	assign out_valid = name_vld_q | status_vld_q;
	assign pop       = out_valid & out_ready;
	assign can_push  = !out_valid || (pop && (name_vld_q ^ status_vld_q));
	assign res       = name_vld_q ? name_q : status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_vld_q   <= 1'b0;
			status_vld_q <= 1'b0;
		end else if (push) begin
			name_vld_q   <= step.name_vld;
			status_vld_q <= step.status_vld;
		end else if (pop) begin
			if (name_vld_q)
				name_vld_q <= 1'b0;
			else
				status_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			name_q   <= step.name_res;
			status_q <= step.status_res;
		end
	end

endmodule

>>> hw/rtl/jpeg_zip_filename_scanner.sv
// ----------------------------------------------------------------------------
// jpeg_zip_filename_scanner
// Streams a file bytewise and reports archived filenames and JPEG markers.
// ----------------------------------------------------------------------------
// Bytes enter on the in channel (data_byte, end_of_stream) with in_valid and
// in_ready; results leave on the out channel with out_valid and out_ready.
// A name byte of a ZIP local header gives one result of kind 0, and the byte
// that carries end_of_stream adds a status result of kind 1 after it; the
// last result of each byte has last set.
// A byte is registered on its transfer, parsed from the input register once
// the output register can take its results, and the results are registered there.
// One byte is taken every cycle while the receiver keeps up; a byte that
// gives both a name byte and a status sends them in turn, which holds the next
// byte until the status leaves. When the receiver stalls, results wait in the
// output register and in_ready drops once the input register is also full.
// Reset clears the window, flags, count and parse state; after the final
// byte of a stream the same state returns to reset values on its own.
// ----------------------------------------------------------------------------
module jpeg_zip_filename_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  name_byte,
	output logic [15:0] file_index,
	output logic        last_of_name,
	output logic        jpg_start_seen,
	output logic        jpg_end_seen,
	output logic [15:0] files_found,
	output logic        last
);
	import jzfs_pkg::*;

	logic    vld_s1;
	logic [7:0] byte_s1;
	logic    eos_s1;
	logic    can_push, fire;
	step_t   step;
	result_t res;

	assign fire     = vld_s1 & can_push;
	assign in_ready = !vld_s1 || can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_valid && in_ready)
			vld_s1 <= 1'b1;
		else if (fire)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	jzfs_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.step          (step)
	);

	jzfs_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.step      (step),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign kind           = res.kind;
	assign name_byte      = res.name_byte;
	assign file_index     = res.file_index;
	assign last_of_name   = res.last_of_name;
	assign jpg_start_seen = res.jpg_start_seen;
	assign jpg_end_seen   = res.jpg_end_seen;
	assign files_found    = res.files_found;
	assign last           = res.last;

endmodule

>>> dv/jzfs_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jzfs_scan_checker
// Watches both channels of the scanner, predicts and compares its results.
// ----------------------------------------------------------------------------
// Every byte transfer on the input channel runs through a local copy of the
// scan: marker flags, signature search, header skip, name length capture and
// name emission. The results it yields are queued in order, and each transfer
// on the output channel is compared with the oldest one. Mismatches and
// results that arrive with nothing queued are counted; the number of results
// still queued is handed out for the end-of-run check.
// ----------------------------------------------------------------------------
module jzfs_scan_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [7:0]  name_byte,
	input  logic [15:0] file_index,
	input  logic        last_of_name,
	input  logic        jpg_start_seen,
	input  logic        jpg_end_seen,
	input  logic [15:0] files_found,
	input  logic        last,
	output int          mismatches,
	output int          awaited
);
	import jzfs_pkg::*;

	typedef enum logic [2:0] {
		ScanHunt,
		ScanHeader,
		ScanLenLo,
		ScanLenHi,
		ScanExtra,
		ScanName
	} scan_phase_t;

	logic [23:0] recent_bytes;
	logic [1:0]  recent_fill;
	scan_phase_t scan_phase;
	logic [4:0]  skip_cnt;
	logic [15:0] name_len;
	logic [15:0] name_left;
	logic [15:0] headers_seen;
	logic        soi_flag;
	logic        eoi_flag;

	result_t awaited_reports[$];
	result_t seen_res;
	result_t want_res;

	function automatic string describe_result(result_t r);
		return $sformatf(
			"kind=%0d name=%02h idx=%0d eon=%0d soi=%0d eoi=%0d files=%0d last=%0d",
			r.kind, r.name_byte, r.file_index, r.last_of_name, r.jpg_start_seen,
			r.jpg_end_seen, r.files_found, r.last);
	endfunction

	task clear_scan();
		recent_bytes = '0;
		recent_fill = '0;
		scan_phase = ScanHunt;
		skip_cnt = '0;
		name_len = '0;
		name_left = '0;
		headers_seen = '0;
		soi_flag = 1'b0;
		eoi_flag = 1'b0;
	endtask

	task scan_byte(input logic [7:0] b, input logic eos);
		result_t name_res;
		result_t stat_res;
		logic    got_name;
		got_name = 1'b0;
		name_res = '0;
		stat_res = '0;
		if (recent_fill != 2'd0 && recent_bytes[7:0] == MarkPrefix) begin
			if (b == MarkSoi)
				soi_flag = 1'b1;
			if (b == MarkEoi)
				eoi_flag = 1'b1;
		end
		case (scan_phase)
			ScanHunt: begin
				if (recent_fill == 2'd3 && recent_bytes == {SigByte0, SigByte1, SigByte2}
						&& b == SigByte3) begin
					if (headers_seen != CountMax)
						headers_seen = headers_seen + 16'd1;
					skip_cnt = '0;
					scan_phase = ScanHeader;
				end
			end
			ScanHeader: begin
				skip_cnt = skip_cnt + 5'd1;
				if (skip_cnt >= HdrSkip) begin
					skip_cnt = '0;
					scan_phase = ScanLenLo;
				end
			end
			ScanLenLo: begin
				name_len = {8'h00, b};
				scan_phase = ScanLenHi;
			end
			ScanLenHi: begin
				name_len = {b, name_len[7:0]};
				name_left = name_len;
				skip_cnt = '0;
				scan_phase = ScanExtra;
			end
			ScanExtra: begin
				skip_cnt = skip_cnt + 5'd1;
				if (skip_cnt >= ExtSkip) begin
					skip_cnt = '0;
					if (name_left == 16'd0)
						scan_phase = ScanHunt;
					else
						scan_phase = ScanName;
				end
			end
			ScanName: begin
				name_left = name_left - 16'd1;
				got_name = 1'b1;
				name_res.kind = KindName;
				name_res.name_byte = b;
				name_res.file_index = (headers_seen == 16'd0) ? 16'd0 : headers_seen - 16'd1;
				name_res.last_of_name = (name_left == 16'd0);
				if (name_left == 16'd0)
					scan_phase = ScanHunt;
			end
			default: scan_phase = ScanHunt;
		endcase
		recent_bytes = {recent_bytes[15:0], b};
		if (recent_fill != 2'd3)
			recent_fill = recent_fill + 2'd1;
		if (eos) begin
			stat_res.kind = KindStatus;
			stat_res.jpg_start_seen = soi_flag;
			stat_res.jpg_end_seen = eoi_flag;
			stat_res.files_found = headers_seen;
			stat_res.last = 1'b1;
			clear_scan();
		end else if (got_name) begin
			name_res.last = 1'b1;
		end
		if (got_name)
			awaited_reports.push_back(name_res);
		if (eos)
			awaited_reports.push_back(stat_res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			awaited_reports.delete();
			mismatches = 0;
			awaited <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_res = {kind, name_byte, file_index, last_of_name, jpg_start_seen,
					jpg_end_seen, files_found, last};
				if (awaited_reports.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with none expected: %s", $time,
							describe_result(seen_res));
					mismatches = mismatches + 1;
				end else begin
					want_res = awaited_reports.pop_front();
					if (seen_res !== want_res) begin
						if (mismatches < 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected %s", describe_result(want_res));
							$display("  actual   %s", describe_result(seen_res));
						end
						mismatches = mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready)
				scan_byte(data_byte, end_of_stream);
			awaited <= awaited_reports.size();
		end
	end

endmodule

>>> dv/tb_jpeg_zip_filename_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jpeg_zip_filename_scanner
// Stimulus and verdict for the JPEG/ZIP filename scanner.
// ----------------------------------------------------------------------------
// Files are built byte by byte and streamed in, end_of_stream on the final
// byte of each. A few hand-made files come first: marker pairs, a marker
// split across two files, an empty name, a signature hidden in a name and
// one spanning its end, a name byte and status from one byte, and headers
// and names cut short. Random files follow, made mostly of complete local
// headers with random content mixed with noise, markers, broken signatures
// and truncated headers. Both sides stall at random, with quiet stretches.
// ----------------------------------------------------------------------------
module tb_jpeg_zip_filename_scanner;
	import jzfs_pkg::*;

	localparam int unsigned CycleLimit   = 2000000;
	localparam int          SettleCycles = 4;
	localparam int          RandomBytes  = 1700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_stream = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  name_byte;
	logic [15:0] file_index;
	logic        last_of_name;
	logic        jpg_start_seen;
	logic        jpg_end_seen;
	logic [15:0] files_found;
	logic        last;

	int          mismatches;
	int          awaited;
	logic [31:0] cycles = '0;
	int          rx_hold = 0;
	int          bytes_sent = 0;
	logic [7:0]  file_bytes[$];

	wire calm = (cycles[9:7] == 3'd0);

	jpeg_zip_filename_scanner DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_stream  (end_of_stream),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.name_byte      (name_byte),
		.file_index     (file_index),
		.last_of_name   (last_of_name),
		.jpg_start_seen (jpg_start_seen),
		.jpg_end_seen   (jpg_end_seen),
		.files_found    (files_found),
		.last           (last)
	);

	jzfs_scan_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_stream  (end_of_stream),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.name_byte      (name_byte),
		.file_index     (file_index),
		.last_of_name   (last_of_name),
		.jpg_start_seen (jpg_start_seen),
		.jpg_end_seen   (jpg_end_seen),
		.files_found    (files_found),
		.last           (last),
		.mismatches     (mismatches),
		.awaited        (awaited)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 32'd1;
		if (cycles == CycleLimit) begin
			$display("tb_jpeg_zip_filename_scanner: done, errors");
			$finish;
		end
	end

	function automatic int stall_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] rand_byte();
		if ($urandom_range(0, 9) >= 4)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 6))
			0: return SigByte0;
			1: return SigByte1;
			2: return SigByte2;
			3: return SigByte3;
			4: return MarkPrefix;
			5: return MarkSoi;
			default: return MarkEoi;
		endcase
	endfunction

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_ready <= 1'b0;
		end else if (arst_n && !calm && $urandom_range(0, 7) == 0) begin
			rx_hold <= stall_length() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task put_word(input logic [31:0] w, input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(w[31 - 8 * i -: 8]);
	endtask

	task push_tail(input logic [15:0] len, input int name_n);
		repeat (22) file_bytes.push_back(rand_byte());
		file_bytes.push_back(len[7:0]);
		file_bytes.push_back(len[15:8]);
		repeat (2) file_bytes.push_back(rand_byte());
		repeat (name_n) file_bytes.push_back(rand_byte());
	endtask

	task push_header(input logic [15:0] len, input int name_n);
		put_word({SigByte0, SigByte1, SigByte2, SigByte3}, 4);
		push_tail(len, name_n);
	endtask

	task send_byte(input logic [7:0] b, input logic eos);
		int gap;
		gap = (calm || $urandom_range(0, 99) < 65) ? 0 : stall_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task send_file();
		if (file_bytes.size() == 0)
			file_bytes.push_back(rand_byte());
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		file_bytes.delete();
	endtask

	task drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task build_random_file();
		int          segs;
		int          cut;
		logic [15:0] len;
		logic        stop;
		segs = $urandom_range(1, 5);
		stop = 1'b0;
		for (int s = 0; s < segs && !stop; s++) begin
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 8)) file_bytes.push_back(rand_byte());
				2: begin
					file_bytes.push_back(MarkPrefix);
					file_bytes.push_back($urandom_range(0, 1) ? MarkSoi : MarkEoi);
				end
				3: begin
					put_word({SigByte0, SigByte1, SigByte2, 8'h00}, $urandom_range(1, 3));
					file_bytes.push_back(rand_byte());
				end
				4, 5, 6, 7: begin
					len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
					push_header(len, int'(len));
				end
				8: begin
					len = 16'($urandom_range(11, 80));
					push_header(len, int'(len));
				end
				default: begin
					len = 16'($urandom_range(0, 65535));
					push_header(len, $urandom_range(0, 20));
					stop = 1'b1;
				end
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, 30);
			while (cut > 0 && file_bytes.size() > 1) begin
				void'(file_bytes.pop_back());
				cut--;
			end
		end
	endtask

	initial begin
		int target;
		logic paused;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_word({MarkPrefix, MarkSoi, MarkPrefix, 8'h00}, 3);
		send_file();
		put_word({MarkEoi, 24'h000000}, 1);
		send_file();

		put_word({MarkPrefix, MarkEoi, SigByte0, SigByte1}, 4);
		put_word({SigByte2, SigByte3, 16'h0000}, 2);
		push_tail(16'h0000, 0);
		put_word({MarkPrefix, MarkSoi, 16'h0000}, 2);
		send_file();

		push_header(16'd6, 0);
		put_word({SigByte0, SigByte1, SigByte2, SigByte3}, 4);
		put_word({SigByte0, SigByte1, 16'h0000}, 2);
		put_word({SigByte2, SigByte3, 16'h0000}, 2);
		push_tail(16'd1, 1);
		send_file();

		put_word({SigByte0, SigByte1, SigByte2, SigByte3}, 4);
		repeat (10) file_bytes.push_back(8'hFF);
		send_file();
		push_header(16'hFFFF, 2);
		send_file();
		drain();

		target = bytes_sent + RandomBytes;
		paused = 1'b0;
		while (bytes_sent < target) begin
			build_random_file();
			send_file();
			if (!paused && bytes_sent > target - RandomBytes / 2) begin
				drain();
				paused = 1'b1;
			end
		end
		drain();

		if (mismatches == 0 && awaited == 0)
			$display("tb_jpeg_zip_filename_scanner: done, clean");
		else
			$display("tb_jpeg_zip_filename_scanner: done, errors");
		$finish;
	end

endmodule
